/* sv/cvk_pkg.sv */
// ============================================================================
// cvk_pkg - shared types and constants of the 3x3 convolution block
// Register indexes, reset values, field widths and the per-stage control
// word that travels with every pixel through the pipeline.
// ============================================================================
`default_nettype none

package cvk_pkg;

   // Default geometry and coefficient format
   localparam int MAX_LINE_DEF  = 1024;
   localparam int COEF_BITS_DEF = 8;

   // Field widths fixed by the stream format
   localparam int PIX_W     = 8;
   localparam int LINE_W    = 16;
   localparam int CSR_W     = 24;
   localparam int CSR_IDX_W = 3;

   // Low quotient bits kept by the divider (one output byte)
   localparam int QUOT_W = 8;

   // Smallest line length and line count of an image
   localparam int MIN_DIM = 3;

   // Register reset values
   localparam logic [CSR_W-1:0]  COEF_TOP_RST = 24'hFF00FF;
   localparam logic [CSR_W-1:0]  COEF_MID_RST = 24'hFF01FF;
   localparam logic [CSR_W-1:0]  COEF_BOT_RST = 24'hFF00FF;
   localparam int                LEN_RST      = 512;
   localparam logic [LINE_W-1:0] CNT_RST      = 16'd512;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_TOP = 3'd0,
      CSR_COEF_MID = 3'd1,
      CSR_COEF_BOT = 3'd2,
      CSR_LINE_LEN = 3'd3,
      CSR_LINE_CNT = 3'd4
   } cvk_csr_type;

   // Control word carried beside each pixel transaction
   typedef struct packed {
      logic valid;   // stage holds a live transaction
      logic neg;     // quotient must be negated
      logic last;    // last interior pixel of the image
   } cvk_ctl_type;

endpackage

`default_nettype wire

/* sv/cvk_ram.sv */
// ============================================================================
// cvk_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered on read enable.
// ============================================================================
`default_nettype none

module cvk_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read word; hold it until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/cvk_div_cell.sv */
// ============================================================================
// cvk_div_cell - one restoring-division cell of the divider chain
// Resolves one quotient bit per transaction and hands the partial remainder,
// the remaining dividend bits and the tags to the next cell.
// ============================================================================
`default_nettype none

module cvk_div_cell
   import cvk_pkg::*;
#(
   parameter int KM_W  = 11,
   parameter int QW    = 20,
   parameter int TAG_W = 26
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // upstream side
   output logic                   ready,
   input  wire cvk_ctl_type       ctl_i,
   input  wire logic [KM_W-1:0]   rem_i,
   input  wire logic [QW-1:0]     dvd_i,
   input  wire logic [KM_W-1:0]   dvs_i,
   input  wire logic [QUOT_W-1:0] quot_i,
   input  wire logic [TAG_W-1:0]  tag_i,
   // downstream side
   input  wire logic              next_ready,
   output cvk_ctl_type            ctl_o,
   output logic      [KM_W-1:0]   rem_o,
   output logic      [QW-1:0]     dvd_o,
   output logic      [KM_W-1:0]   dvs_o,
   output logic      [QUOT_W-1:0] quot_o,
   output logic      [TAG_W-1:0]  tag_o
);

   cvk_ctl_type       ctl_ff;
   logic [KM_W-1:0]   rem_ff, rem_in;
   logic [QW-1:0]     dvd_ff, dvd_in;
   logic [KM_W-1:0]   dvs_ff;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [TAG_W-1:0]  tag_ff;

   logic [KM_W:0]     rem_sh;
   logic [KM_W:0]     diff;
   logic              fits;

   // Load when empty or when the next cell takes the current transaction
   assign ready = !ctl_ff.valid || next_ready;

   // Shift in the next dividend bit, trial-subtract the divisor
   always_comb begin
      rem_sh  = {rem_i, dvd_i[QW-1]};
      diff    = rem_sh - {1'b0, dvs_i};
      fits    = rem_sh >= {1'b0, dvs_i};
      rem_in  = fits ? diff[KM_W-1:0] : rem_sh[KM_W-1:0];
      dvd_in  = {dvd_i[QW-2:0], 1'b0};
      quot_in = {quot_i[QUOT_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (ready) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (ready) begin
         rem_ff  <= rem_in;
         dvd_ff  <= dvd_in;
         dvs_ff  <= dvs_i;
         quot_ff <= quot_in;
         tag_ff  <= tag_i;
      end
   end

   assign ctl_o  = ctl_ff;
   assign rem_o  = rem_ff;
   assign dvd_o  = dvd_ff;
   assign dvs_o  = dvs_ff;
   assign quot_o = quot_ff;
   assign tag_o  = tag_ff;

endmodule

`default_nettype wire

/* sv/conv3x3_kernel_sum_normalized.sv */
// ============================================================================
// conv3x3_kernel_sum_normalized - streaming 3x3 convolution with kernel-sum
// normalization
// Keeps two previous lines in a RAM and a 3x3 window of registers, multiplies
// the window by the signed kernel, divides by the kernel sum in a chain of
// restoring-division cells and emits the low byte for every interior pixel.
// ============================================================================
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------
//  req     | in  | req_tvalid/req_tready | tdata: pixel_in; tuser: frame_start
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: pixel_out, out_line,
//          |     |                       | out_column; tlast: frame_last
//  csr     | in  | csr_wen               | csr_index, csr_wdata
//
//  One pixel transaction is taken per cycle when the result side keeps up.
//  From acceptance to result a pixel passes four front stages (line RAM
//  read, multiply, sum, magnitude), COEF_BITS + 12 divider cells and one
//  output register. Empty stages are filled while the result register is
//  stalled, so input is taken until the pipeline is full.
//  Reset clears position counters, window and pipeline valid bits; the line
//  RAM is not cleared.
//
`default_nettype none

module conv3x3_kernel_sum_normalized
   import cvk_pkg::*;
#(
   parameter  int MAX_LINE  = MAX_LINE_DEF,
   parameter  int COEF_BITS = COEF_BITS_DEF,
   localparam int CW        = $clog2(MAX_LINE),
   localparam int OUT_W     = ((PIX_W + LINE_W + CW + 7) / 8) * 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // pixel input
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [PIX_W-1:0]     req_tdata,   // [7:0] pixel_in
   input  wire logic [0:0]           req_tuser,   // [0] frame_start
   // result output
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [OUT_W-1:0]     rsp_tdata,   // pixel_out, out_line, out_column, zero pad
   output logic                      rsp_tlast,
   // configuration
   input  wire logic                 csr_wen,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int LEN_W   = $clog2(MAX_LINE + 1);
   localparam int EW      = CW + 2;
   localparam int TAG_W   = LINE_W + CW;
   localparam int ROW_W   = (3 * COEF_BITS > CSR_W) ? 3 * COEF_BITS : CSR_W;
   localparam int PROD_W  = COEF_BITS + 9;
   localparam int SUM_W   = COEF_BITS + 13;
   localparam int QW      = SUM_W - 1;
   localparam int K_W     = COEF_BITS + 4;
   localparam int KM_W    = COEF_BITS + 3;
   localparam int LEN_RV  = (LEN_RST > MAX_LINE) ? MAX_LINE : LEN_RST;
   localparam int WORD_W  = 2 * PIX_W;

   // -------------------------------------------------------------------------
   // Configuration registers
   // -------------------------------------------------------------------------
   logic [CSR_W-1:0]  coef_top_ff, coef_mid_ff, coef_bot_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [LINE_W-1:0] cnt_ff;

   // Write the addressed register; ignore unused indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_top_ff <= COEF_TOP_RST;
         coef_mid_ff <= COEF_MID_RST;
         coef_bot_ff <= COEF_BOT_RST;
         len_ff      <= LEN_W'(LEN_RV);
         cnt_ff      <= CNT_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_COEF_TOP: coef_top_ff <= csr_wdata;
            CSR_COEF_MID: coef_mid_ff <= csr_wdata;
            CSR_COEF_BOT: coef_bot_ff <= csr_wdata;
            CSR_LINE_LEN: len_ff      <= csr_wdata[LEN_W-1:0];
            CSR_LINE_CNT: cnt_ff      <= csr_wdata[LINE_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp geometry to the supported range
   logic [LEN_W-1:0]  len_eff;
   logic [LINE_W-1:0] cnt_eff;

   always_comb begin
      if (len_ff < LEN_W'(MIN_DIM)) begin
         len_eff = LEN_W'(MIN_DIM);
      end else if (len_ff > LEN_W'(MAX_LINE)) begin
         len_eff = LEN_W'(MAX_LINE);
      end else begin
         len_eff = len_ff;
      end
      cnt_eff = (cnt_ff < LINE_W'(MIN_DIM)) ? LINE_W'(MIN_DIM) : cnt_ff;
   end

   // Unpack the kernel into signed coefficients
   logic [ROW_W-1:0]            rows [3];
   logic signed [COEF_BITS-1:0] coef [3][3];

   always_comb begin
      rows[0] = ROW_W'(coef_top_ff);
      rows[1] = ROW_W'(coef_mid_ff);
      rows[2] = ROW_W'(coef_bot_ff);
      for (int r = 0; r < 3; r++) begin
         for (int j = 0; j < 3; j++) begin
            coef[r][j] = $signed(rows[r][j*COEF_BITS +: COEF_BITS]);
         end
      end
   end

   // Kernel sum and divisor magnitude; a zero sum divides by one
   logic signed [K_W-1:0] k_ff, k_in;
   logic [K_W-1:0]        k_abs;
   logic [KM_W-1:0]       kmag_ff, kmag_in;
   logic                  kneg_ff;

   always_comb begin
      k_in = '0;
      for (int r = 0; r < 3; r++) begin
         for (int j = 0; j < 3; j++) begin
            k_in = k_in + K_W'(coef[r][j]);
         end
      end
      k_abs   = k_ff[K_W-1] ? (K_W'(0) - k_ff) : k_ff;
      kmag_in = (k_ff == '0) ? KM_W'(1) : k_abs[KM_W-1:0];
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      kmag_ff <= kmag_in;
      kneg_ff <= k_ff[K_W-1];
   end

   // -------------------------------------------------------------------------
   // Stage A: position counters and line RAM read
   // -------------------------------------------------------------------------
   logic              acc;
   logic              a_load, a_adv, p_load;
   logic              a_valid_ff, a_make_ff, a_last_ff;
   logic [PIX_W-1:0]  a_pix_ff;
   logic [CW-1:0]     a_col_ff;
   logic [TAG_W-1:0]  a_tag_ff, a_tag_in;
   logic              fwd_ff, fwd_in;
   logic [WORD_W-1:0] fwd_data_ff;

   logic [LINE_W-1:0] line_ff, line_in, l_cur;
   logic [CW-1:0]     col_ff, col_in, c_cur;
   logic              make_in, last_in;

   logic [WORD_W-1:0] ram_rd_data, above_word, wr_word;
   logic [PIX_W-1:0]  above1, above2;

   assign a_load     = !a_valid_ff || p_load;
   assign a_adv      = a_valid_ff && p_load;
   assign req_tready = a_load;
   assign acc        = req_tvalid && a_load;

   // Resolve the position of the incoming pixel and the next position
   always_comb begin
      l_cur = req_tuser[0] ? '0 : line_ff;
      c_cur = req_tuser[0] ? '0 : col_ff;

      make_in = (l_cur >= LINE_W'(2)) && (c_cur >= CW'(2)) && (l_cur < cnt_eff)
                && (EW'(c_cur) < EW'(len_eff));
      last_in = (l_cur == cnt_eff - LINE_W'(1))
                && (EW'(c_cur) == EW'(len_eff) - EW'(1));
      a_tag_in = {LINE_W'(l_cur - LINE_W'(1)), CW'(c_cur - CW'(1))};

      if (EW'(c_cur) + EW'(1) >= EW'(len_eff)) begin
         col_in  = '0;
         line_in = ((LINE_W + 1)'(l_cur) + (LINE_W + 1)'(1) >= (LINE_W + 1)'(cnt_eff))
                   ? '0 : l_cur + LINE_W'(1);
      end else begin
         col_in  = c_cur + CW'(1);
         line_in = (l_cur >= cnt_eff) ? '0 : l_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff    <= '0;
         col_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         if (acc) begin
            line_ff <= line_in;
            col_ff  <= col_in;
         end
         if (a_load) begin
            a_valid_ff <= req_tvalid;
         end
      end
   end

   // Forward the word written in the same cycle as a read of the same column
   assign fwd_in = a_adv && (a_col_ff == c_cur);

   always_ff @(posedge clock) begin
      if (acc) begin
         a_pix_ff    <= req_tdata;
         a_col_ff    <= c_cur;
         a_make_ff   <= make_in;
         a_last_ff   <= last_in;
         a_tag_ff    <= a_tag_in;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= wr_word;
      end
   end

   assign above_word = fwd_ff ? fwd_data_ff : ram_rd_data;
   assign above1     = above_word[PIX_W-1:0];
   assign above2     = above_word[WORD_W-1:PIX_W];
   assign wr_word    = {above1, a_pix_ff};

   // Two line stores side by side: upper byte two lines up, lower one line up
   cvk_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_LINE)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (a_adv),
      .wr_addr (a_col_ff),
      .wr_data (wr_word),
      .rd_en   (acc),
      .rd_addr (c_cur),
      .rd_data (ram_rd_data)
   );

   // -------------------------------------------------------------------------
   // Window shift and stage P: nine products
   // -------------------------------------------------------------------------
   logic [PIX_W-1:0] win_ff [3][3];
   logic [PIX_W-1:0] win_in [3][3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
      end
      win_in[0][2] = above2;
      win_in[1][2] = above1;
      win_in[2][2] = a_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[r][j] <= '0;
            end
         end
      end else if (a_adv) begin
         win_ff <= win_in;
      end
   end

   logic                     s_load;
   cvk_ctl_type              p_ctl_ff, p_ctl_in;
   logic [TAG_W-1:0]         p_tag_ff;
   logic signed [PROD_W-1:0] p_prod_ff [9];
   logic signed [PROD_W-1:0] p_prod_in [9];

   assign p_load = !p_ctl_ff.valid || s_load;

   always_comb begin
      p_ctl_in.valid = a_valid_ff && a_make_ff;
      p_ctl_in.neg   = 1'b0;
      p_ctl_in.last  = a_last_ff;
      for (int r = 0; r < 3; r++) begin
         for (int j = 0; j < 3; j++) begin
            p_prod_in[r*3 + j] = PROD_W'($signed({1'b0, win_in[r][j]}))
                                 * PROD_W'(coef[r][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ctl_ff <= '0;
      end else if (p_load) begin
         p_ctl_ff <= p_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p_load) begin
         p_prod_ff <= p_prod_in;
         p_tag_ff  <= a_tag_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Stage S: sum of products
   // -------------------------------------------------------------------------
   logic                    n_load;
   cvk_ctl_type             s_ctl_ff;
   logic [TAG_W-1:0]        s_tag_ff;
   logic signed [SUM_W-1:0] s_sum_ff, s_sum_in;

   assign s_load = !s_ctl_ff.valid || n_load;

   always_comb begin
      s_sum_in = '0;
      for (int i = 0; i < 9; i++) begin
         s_sum_in = s_sum_in + SUM_W'(p_prod_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ctl_ff <= '0;
      end else if (s_load) begin
         s_ctl_ff <= p_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s_load) begin
         s_sum_ff <= s_sum_in;
         s_tag_ff <= p_tag_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Stage N: dividend magnitude and quotient sign
   // -------------------------------------------------------------------------
   cvk_ctl_type      n_ctl_ff, n_ctl_in;
   logic [TAG_W-1:0] n_tag_ff;
   logic [QW-1:0]    n_dvd_ff;
   logic [KM_W-1:0]  n_dvs_ff;
   logic [SUM_W-1:0] sum_abs;

   always_comb begin
      sum_abs        = s_sum_ff[SUM_W-1] ? (SUM_W'(0) - s_sum_ff) : s_sum_ff;
      n_ctl_in       = s_ctl_ff;
      n_ctl_in.neg   = s_sum_ff[SUM_W-1] ^ kneg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ctl_ff <= '0;
      end else if (n_load) begin
         n_ctl_ff <= n_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_load) begin
         n_dvd_ff <= sum_abs[QW-1:0];
         n_dvs_ff <= kmag_ff;
         n_tag_ff <= s_tag_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Divider chain: one quotient bit per cell
   // -------------------------------------------------------------------------
   cvk_ctl_type       ch_ctl  [QW+1];
   logic [KM_W-1:0]   ch_rem  [QW+1];
   logic [QW-1:0]     ch_dvd  [QW+1];
   logic [KM_W-1:0]   ch_dvs  [QW+1];
   logic [QUOT_W-1:0] ch_quot [QW+1];
   logic [TAG_W-1:0]  ch_tag  [QW+1];
   logic              ch_rdy  [QW+1];
   logic              o_load;

   assign ch_ctl[0]  = n_ctl_ff;
   assign ch_rem[0]  = '0;
   assign ch_dvd[0]  = n_dvd_ff;
   assign ch_dvs[0]  = n_dvs_ff;
   assign ch_quot[0] = '0;
   assign ch_tag[0]  = n_tag_ff;
   assign ch_rdy[QW] = o_load;
   assign n_load     = !n_ctl_ff.valid || ch_rdy[0];

   for (genvar g = 0; g < QW; g++) begin : g_cell
      cvk_div_cell #(
         .KM_W  (KM_W),
         .QW    (QW),
         .TAG_W (TAG_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ready      (ch_rdy[g]),
         .ctl_i      (ch_ctl[g]),
         .rem_i      (ch_rem[g]),
         .dvd_i      (ch_dvd[g]),
         .dvs_i      (ch_dvs[g]),
         .quot_i     (ch_quot[g]),
         .tag_i      (ch_tag[g]),
         .next_ready (ch_rdy[g+1]),
         .ctl_o      (ch_ctl[g+1]),
         .rem_o      (ch_rem[g+1]),
         .dvd_o      (ch_dvd[g+1]),
         .dvs_o      (ch_dvs[g+1]),
         .quot_o     (ch_quot[g+1]),
         .tag_o      (ch_tag[g+1])
      );
   end

   // -------------------------------------------------------------------------
   // Output register: apply the sign, hold while stalled
   // -------------------------------------------------------------------------
   cvk_ctl_type      o_ctl_ff;
   logic [PIX_W-1:0] o_pix_ff, o_pix_in;
   logic [TAG_W-1:0] o_tag_ff;

   assign o_load   = !o_ctl_ff.valid || rsp_tready;
   assign o_pix_in = ch_ctl[QW].neg ? (PIX_W'(0) - ch_quot[QW][PIX_W-1:0])
                                    : ch_quot[QW][PIX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         o_ctl_ff <= '0;
      end else if (o_load) begin
         o_ctl_ff <= ch_ctl[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (o_load) begin
         o_pix_ff <= o_pix_in;
         o_tag_ff <= ch_tag[QW];
      end
   end

   // Pack pixel lowest, then line, then column
   assign rsp_tvalid = o_ctl_ff.valid;
   assign rsp_tlast  = o_ctl_ff.last;
   assign rsp_tdata  = OUT_W'({o_tag_ff[CW-1:0], o_tag_ff[TAG_W-1:CW], o_pix_ff});

endmodule

`default_nettype wire

/* sv/cvk_checker.sv */
// ============================================================================
// cvk_checker - port-level checks of the 3x3 convolution block
// Watches the stream ports for reset behavior, stall holding and result
// positions, and is bound to the top level.
// ============================================================================
`default_nettype none

module cvk_checker
   import cvk_pkg::*;
#(
   parameter  int MAX_LINE = MAX_LINE_DEF,
   localparam int CW       = $clog2(MAX_LINE),
   localparam int OUT_W    = ((PIX_W + LINE_W + CW + 7) / 8) * 8
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [OUT_W-1:0] rsp_tdata,
   input wire logic             rsp_tlast
);

   logic [LINE_W-1:0] res_line;
   logic [CW-1:0]     res_col;
   logic              in_xact;

   assign res_line = rsp_tdata[PIX_W +: LINE_W];
   assign res_col  = rsp_tdata[PIX_W + LINE_W +: CW];
   assign in_xact  = req_tvalid && req_tready;

   // Pipeline is empty after reset: no result, room for a pixel
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready right after reset");

   // A stalled result holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Results never lie on line 0 or column 0
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (res_line != '0) && (res_col != '0))
      else $error("result on a border position");

   // No result can appear right after reset drops with no pixel taken
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !in_xact |=> !rsp_tvalid)
      else $error("result without a preceding transaction");

endmodule

bind conv3x3_kernel_sum_normalized cvk_checker #(
   .MAX_LINE (MAX_LINE)
) u_cvk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
